/* rtl/mf3s_pkg.sv */
// Shared types, constants and median network stages of the 3x3 median filter.
package mf3s_pkg;

    localparam int PIXEL_W       = 8;
    localparam int WIDTH_W       = 13;
    localparam int HEIGHT_W      = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;
    localparam int LEVEL_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;

    // 3 columns x 3 rows; index = column * 3 + row, column 0 oldest, row 0 top
    typedef logic [8:0][PIXEL_W-1:0] pix9_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [PIXEL_W-1:0] above;
        logic [PIXEL_W-1:0] two_above;
        logic               emit;
        logic               interior;
        logic               eof;
    } q_entry_t;

    // compare and exchange: p[i] ends up the smaller one
    function automatic pix9_t cx(input pix9_t p, input logic [3:0] i, input logic [3:0] j);
        pix9_t r;
        r = p;
        if (p[i] > p[j]) begin
            r[i] = p[j];
            r[j] = p[i];
        end
        return r;
    endfunction

    // sort each group of three
    function automatic pix9_t med_stage1(input pix9_t p);
        pix9_t r;
        r = p;
        r = cx(r, 4'd1, 4'd2);
        r = cx(r, 4'd4, 4'd5);
        r = cx(r, 4'd7, 4'd8);
        r = cx(r, 4'd0, 4'd1);
        r = cx(r, 4'd3, 4'd4);
        r = cx(r, 4'd6, 4'd7);
        r = cx(r, 4'd1, 4'd2);
        r = cx(r, 4'd4, 4'd5);
        r = cx(r, 4'd7, 4'd8);
        return r;
    endfunction

    // max of mins, min of maxes, median of medians
    function automatic pix9_t med_stage2(input pix9_t p);
        pix9_t r;
        r = p;
        r = cx(r, 4'd0, 4'd3);
        r = cx(r, 4'd5, 4'd8);
        r = cx(r, 4'd4, 4'd7);
        r = cx(r, 4'd3, 4'd6);
        r = cx(r, 4'd1, 4'd4);
        r = cx(r, 4'd2, 4'd5);
        r = cx(r, 4'd4, 4'd7);
        return r;
    endfunction

    // median lands in element 4
    function automatic pix9_t med_stage3(input pix9_t p);
        pix9_t r;
        r = p;
        r = cx(r, 4'd4, 4'd2);
        r = cx(r, 4'd6, 4'd4);
        r = cx(r, 4'd4, 4'd2);
        return r;
    endfunction

endpackage

/* rtl/mf3s_front.sv */
// Front end: accepts pixels, tracks raster position, classifies outputs, owns the line store.
module mf3s_front #(
    parameter int MAX_WIDTH = mf3s_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mf3s_pkg::PIXEL_W-1:0]     s_pixel,
    input  logic                             s_flush,
    input  logic [mf3s_pkg::WIDTH_W-1:0]     image_width,
    input  logic [mf3s_pkg::HEIGHT_W-1:0]    image_height,
    input  logic [mf3s_pkg::LEVEL_W-1:0]     q_level,
    output logic                             q_push,
    output mf3s_pkg::q_entry_t               q_entry
);
    import mf3s_pkg::*;

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LINE_W = 2 * PIXEL_W;

    // line store entry: low byte is the row above, high byte the row two above
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];

    logic [WIDTH_W-1:0]  in_col_reg, in_col_next;
    logic [HEIGHT_W-1:0] in_row_reg, in_row_next;
    logic [WIDTH_W-1:0]  out_col_reg, out_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;

    logic                f1_valid_reg;
    logic [ADDR_W-1:0]   f1_addr_reg;
    logic [PIXEL_W-1:0]  f1_pix_reg;
    logic                f1_emit_reg;
    logic                f1_interior_reg;
    logic                f1_eof_reg;
    logic [LINE_W-1:0]   rd_reg;
    logic                fwd_reg;
    logic [LINE_W-1:0]   fwd_data_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [WIDTH_W-1:0]  c0, c_inc, oc0, oc_inc;
    logic [HEIGHT_W-1:0] r0, or0;
    logic [HEIGHT_W:0]   or_inc;
    logic                emit, interior, eof, accept;
    logic [ADDR_W-1:0]   addr0;
    logic [PIXEL_W-1:0]  pix;
    logic [LINE_W-1:0]   line_data, wr_data;

    always_comb begin
        if (image_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (32'(image_width) > MAX_WIDTH) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width;
        end
        h_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;
    end

    assign s_tready = ((LEVEL_W + 1)'(q_level) + (LEVEL_W + 1)'(f1_valid_reg))
                      < (LEVEL_W + 1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign pix      = s_flush ? '0 : s_pixel;

    always_comb begin
        // wrap counters left beyond a reduced width
        if (in_col_reg >= w_eff) begin
            c0 = '0;
            r0 = (in_row_reg != '1) ? in_row_reg + 1'b1 : in_row_reg;
        end else begin
            c0 = in_col_reg;
            r0 = in_row_reg;
        end
        if (out_col_reg >= w_eff) begin
            oc0 = '0;
            or0 = out_row_reg + 1'b1;
        end else begin
            oc0 = out_col_reg;
            or0 = out_row_reg;
        end

        c_inc    = c0 + 1'b1;
        oc_inc   = oc0 + 1'b1;
        or_inc   = (HEIGHT_W + 1)'(or0) + 1'b1;
        emit     = (r0 >= HEIGHT_W'(2)) || ((r0 == HEIGHT_W'(1)) && (c0 != '0));
        interior = (or0 != '0) && (or_inc < (HEIGHT_W + 1)'(h_eff))
                   && (oc0 != '0) && (oc_inc < w_eff);
        eof      = (or_inc >= (HEIGHT_W + 1)'(h_eff)) && (oc_inc == w_eff);
        addr0    = ADDR_W'(c0);

        if (c_inc == w_eff) begin
            in_col_next = '0;
            in_row_next = (r0 != '1) ? r0 + 1'b1 : r0;
        end else begin
            in_col_next = c_inc;
            in_row_next = r0;
        end
        out_col_next = oc0;
        out_row_next = or0;
        if (emit) begin
            if (eof) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (oc_inc == w_eff) begin
                out_col_next = '0;
                out_row_next = or0 + 1'b1;
            end else begin
                out_col_next = oc_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= accept;
            if (accept) begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    // take the stored rows; bypass the write still in flight to the same column
    assign line_data = fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_data   = {line_data[PIXEL_W-1:0], f1_pix_reg};

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg          <= line_mem[addr0];
            fwd_reg         <= f1_valid_reg && (f1_addr_reg == addr0);
            fwd_data_reg    <= wr_data;
            f1_addr_reg     <= addr0;
            f1_pix_reg      <= pix;
            f1_emit_reg     <= emit;
            f1_interior_reg <= interior;
            f1_eof_reg      <= eof;
        end
        if (f1_valid_reg) begin
            line_mem[f1_addr_reg] <= wr_data;
        end
    end

    assign q_push            = f1_valid_reg;
    assign q_entry.pixel     = f1_pix_reg;
    assign q_entry.above     = line_data[PIXEL_W-1:0];
    assign q_entry.two_above = line_data[LINE_W-1:PIXEL_W];
    assign q_entry.emit      = f1_emit_reg;
    assign q_entry.interior  = f1_interior_reg;
    assign q_entry.eof       = f1_eof_reg;

endmodule

/* rtl/mf3s_queue.sv */
// Short queue that decouples the front end from the median back end.
module mf3s_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  mf3s_pkg::q_entry_t            push_entry,
    input  logic                          pop,
    output logic                          head_valid,
    output mf3s_pkg::q_entry_t            head_entry,
    output logic [mf3s_pkg::LEVEL_W-1:0]  level
);
    import mf3s_pkg::*;

    q_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg;

    assign wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (level_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> level_reg != LEVEL_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> level_reg != '0)
        else $error("queue underflow");

    a_level_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> level_reg == $past(level_reg) + 1'b1)
        else $error("queue level lost a push");

endmodule

/* rtl/mf3s_back.sv */
// Back end: shifts the 3x3 window, runs the pipelined median network, holds the result.
module mf3s_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  mf3s_pkg::q_entry_t            q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mf3s_pkg::PIXEL_W-1:0]  m_pixel,
    output logic                          m_eof
);
    import mf3s_pkg::*;

    pix9_t              window_reg, window_next;
    logic               b0_valid_reg, b0_interior_reg, b0_eof_reg;
    pix9_t              s1_p_reg;
    logic [PIXEL_W-1:0] s1_center_reg;
    logic               s1_valid_reg, s1_interior_reg, s1_eof_reg;
    pix9_t              s2_p_reg;
    logic [PIXEL_W-1:0] s2_center_reg;
    logic               s2_valid_reg, s2_interior_reg, s2_eof_reg;
    pix9_t              s3_p;
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               out_eof_reg;
    logic               adv;

    // the whole back end moves only when the output register can take a result
    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && q_valid;

    // drop the oldest column, append {two above, above, current}
    assign window_next = {q_head.pixel, q_head.above, q_head.two_above, window_reg[8:3]};
    assign s3_p        = med_stage3(s2_p_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            b0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                b0_valid_reg  <= q_pop && q_head.emit;
                s1_valid_reg  <= b0_valid_reg;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
            if (q_pop) begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (q_pop) begin
                b0_interior_reg <= q_head.interior;
                b0_eof_reg      <= q_head.eof;
            end
            s1_p_reg        <= med_stage1(window_reg);
            s1_center_reg   <= window_reg[4];
            s1_interior_reg <= b0_interior_reg;
            s1_eof_reg      <= b0_eof_reg;
            s2_p_reg        <= med_stage2(s1_p_reg);
            s2_center_reg   <= s1_center_reg;
            s2_interior_reg <= s1_interior_reg;
            s2_eof_reg      <= s1_eof_reg;
            out_pixel_reg   <= s2_interior_reg ? s3_p[4] : s2_center_reg;
            out_eof_reg     <= s2_eof_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_pixel  = out_pixel_reg;
    assign m_eof    = out_eof_reg;

endmodule

/* rtl/median_filter_3x3_stream_top.sv */
// Top level of the streaming 3x3 median filter: configuration registers and wiring.
//
// Input stream (s_*): one 8-bit grayscale pixel per transaction in raster order;
// s_tuser set marks a flush transaction that enters a zero pixel. After the last pixel
// of a frame, send image_width+1 flush transactions to drain the pending outputs.
// Output stream (m_*): filtered pixels in raster order, m_tlast on the final pixel
// of the frame. Interior pixels get the 3x3 median, border pixels pass unchanged.
// Throughput: one transaction per clock on both sides when the receiver keeps up.
// A result leaves after the transaction that completes its neighbourhood has
// passed the line store read, queue, window shift, two median stages and output
// register; in raster terms a pixel comes out one row plus one pixel later.
// The line store is one read and one write per cycle, with a bypass for the write
// still in flight to the same column.
// When a result waits and m_tready is low, the output register holds it, the back
// end stops, and the four-entry queue absorbs in-flight work before s_tready drops.
// Reset (aresetn low, synchronous) clears positions, the window and the queue and
// loads image_width 640 and image_height 480; the line store is not cleared.
// Write configuration through cfg_* only while no frame is in flight.
module median_filter_3x3_stream_top #(
    parameter int MAX_WIDTH = mf3s_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_index,
    input  logic [mf3s_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_in
    input  logic                              s_tuser,   // [0] flush
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast    // end_of_frame
);
    import mf3s_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                q_push, q_pop, q_valid;
    q_entry_t            q_push_entry, q_head;
    logic [LEVEL_W-1:0]  q_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    mf3s_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_pixel      (s_tdata[PIXEL_W-1:0]),
        .s_flush      (s_tuser),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_level      (q_level),
        .q_push       (q_push),
        .q_entry      (q_push_entry)
    );

    mf3s_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head),
        .level      (q_level)
    );

    mf3s_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_pixel  (m_tdata),
        .m_eof    (m_tlast)
    );

endmodule

/* verif/median_filter_3x3_checker.sv */
// Scoreboard for the 3x3 median filter: predicts every filtered pixel and checks the output stream.
module median_filter_3x3_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [0:0]                      cfg_index,
    input  logic [mf3s_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  logic                            s_tuser,   // [0] flush
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,   // [7:0] pixel_out
    input  logic                            m_tlast,   // end_of_frame
    output int                              mismatches,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import mf3s_pkg::*;

    localparam int MAX_COLS = MAX_WIDTH_DEF;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               eof;
    } filtered_px_t;

    filtered_px_t expected_px[$];

    logic [PIXEL_W-1:0] line_above     [MAX_COLS];
    logic [PIXEL_W-1:0] line_two_above [MAX_COLS];
    logic [2:0][2:0][PIXEL_W-1:0] window;   // [column oldest..newest][row top..bottom]
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    int unsigned in_row, in_col, out_row, out_col;
    int unsigned results_seen;

    initial begin
        mismatches   = 0;
        results_seen = 0;
        foreach (line_above[k]) begin
            line_above[k]     = '0;
            line_two_above[k] = '0;
        end
    end

    function automatic logic [PIXEL_W-1:0] median_of_nine(input logic [2:0][2:0][PIXEL_W-1:0] win);
        logic [PIXEL_W-1:0] v [9];
        logic [PIXEL_W-1:0] x;
        int n;
        int j;
        n = 0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                v[n] = win[c][r];
                n++;
            end
        end
        for (int i = 1; i < 9; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return v[4];
    endfunction

    // advance the filter by one input transaction and queue the pixel it releases, if any
    task automatic filter_item(input logic [PIXEL_W-1:0] data, input logic flush);
        int unsigned w, h, c, orow, ocol;
        logic [PIXEL_W-1:0] px, a, b, wrap_centre, centre, value;
        logic emit, interior, eof;
        w  = (cfg_width == 0) ? 1 : ((cfg_width > MAX_COLS) ? MAX_COLS : cfg_width);
        h  = (cfg_height == 0) ? 1 : cfg_height;
        px = flush ? '0 : data;

        if (in_col >= w) begin
            in_col = 0;
            if (in_row < 16'hFFFF) in_row++;
        end
        if (out_col >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 16'hFFFF;
        end

        c    = in_col;
        emit = (in_row >= 2) || (in_row == 1 && c >= 1);
        // an output at the last column takes its centre from before the shift
        wrap_centre = window[2][1];

        a = line_above[c];
        b = line_two_above[c];
        line_two_above[c] = a;
        line_above[c]     = px;
        window[0]    = window[1];
        window[1]    = window[2];
        window[2][0] = b;
        window[2][1] = a;
        window[2][2] = px;

        in_col = c + 1;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < 16'hFFFF) in_row++;
        end

        if (emit) begin
            orow     = out_row;
            ocol     = out_col;
            centre   = (c == 0) ? wrap_centre : window[1][1];
            interior = orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w;
            value    = interior ? median_of_nine(window) : centre;
            eof      = (orow + 1 >= h) && (ocol + 1 == w);
            expected_px.push_back('{pixel: value, eof: eof});
            if (eof) begin
                in_row  = 0;
                in_col  = 0;
                out_row = 0;
                out_col = 0;
            end else begin
                out_col = ocol + 1;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row = (orow + 1) & 16'hFFFF;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        filtered_px_t want;
        if (!aresetn) begin
            cfg_width  = WIDTH_W'(640);
            cfg_height = HEIGHT_W'(480);
            window     = '0;
            in_row     = 0;
            in_col     = 0;
            out_row    = 0;
            out_col    = 0;
            expected_px.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_IMAGE_WIDTH) cfg_width = cfg_data[WIDTH_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT) cfg_height = cfg_data[HEIGHT_W-1:0];
            end
            if (s_tvalid && s_tready) filter_item(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_px.size() == 0) begin
                    report_mismatch($sformatf("no pixel expected, got %0d tlast %0b",
                                              m_tdata, m_tlast));
                end else begin
                    want = expected_px.pop_front();
                    if (m_tdata !== want.pixel)
                        report_mismatch($sformatf("pixel %0d, expected %0d", m_tdata, want.pixel));
                    if (m_tlast !== want.eof)
                        report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast, want.eof));
                end
                results_seen++;
            end
        end
        outstanding <= expected_px.size();
    end

endmodule

/* verif/testbench.sv */
// Testbench top for the 3x3 median filter: clock, reset, frame stimulus, stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mf3s_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;

    // flush flag in bit 8, pixel below
    localparam logic [8:0] CROSS_FRAME [13] = '{
        9'h0FF, 9'h000, 9'h0FF,
        9'h000, 9'h100, 9'h0FF,
        9'h000, 9'h0FF, 9'h000,
        9'h100, 9'h0C8, 9'h100, 9'h100
    };
    localparam logic [8:0] EARLY_FLUSH_FRAME [7] = '{
        9'h100, 9'h100, 9'h0AA, 9'h055, 9'h100, 9'h100, 9'h100
    };
    localparam logic [8:0] SINGLE_PX_FRAME [3] = '{9'h080, 9'h100, 9'h100};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [0:0]            cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    int                    mismatches;
    int                    outstanding;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned frame_w        = 1;
    int unsigned frame_h        = 1;
    int unsigned items_sent     = 0;
    int unsigned quiet_cycles   = 0;

    median_filter_3x3_stream_top uut (.*);

    median_filter_3x3_checker scoreboard (.*);

    initial forever #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] pixel, input logic flush);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tuser  <= flush;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // hold the input until every predicted pixel has left, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input int unsigned width, input int unsigned height);
        logic [WIDTH_W-1:0]  w_bits;
        logic [HEIGHT_W-1:0] h_bits;
        settle();
        w_bits  = WIDTH_W'(width);
        h_bits  = HEIGHT_W'(height);
        frame_w = (w_bits == 0) ? 1 : ((w_bits > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_bits);
        frame_h = (h_bits == 0) ? 1 : h_bits;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        @(posedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= CFG_DATA_W'(height);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one frame of pixels and its drain; noise swaps pixels and flushes at random
    task automatic send_frame(input int unsigned noise_pct);
        int unsigned pixels;
        logic        stray;
        logic [7:0]  value;
        pixels = frame_w * frame_h;
        for (int unsigned i = 0; i < pixels + frame_w + 1; i++) begin
            stray = $urandom_range(99, 0) < noise_pct;
            value = 8'($urandom_range(255, 0));
            send_item(value, (i < pixels) ? stray : !stray);
        end
    endtask

    initial begin
        int unsigned phase_end;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int mode = 0; mode < 3; mode++) begin
            settle();
            send_idle_pct  = (mode == 0) ? 23 : ((mode == 1) ? 72 : 0);
            recv_stall_pct = (mode == 0) ? 72 : ((mode == 1) ? 23 : 0);

            if (mode == 0) begin
                // flush mid-frame and a pixel in the drain
                configure(3, 3);
                foreach (CROSS_FRAME[k]) send_item(CROSS_FRAME[k][7:0], CROSS_FRAME[k][8]);
                // leading flushes count as pixels of the new frame
                configure(2, 2);
                foreach (EARLY_FLUSH_FRAME[k])
                    send_item(EARLY_FLUSH_FRAME[k][7:0], EARLY_FLUSH_FRAME[k][8]);
                // zero sizes act as one
                configure(0, 0);
                foreach (SINGLE_PX_FRAME[k])
                    send_item(SINGLE_PX_FRAME[k][7:0], SINGLE_PX_FRAME[k][8]);
            end

            phase_end = items_sent + 300;
            while (items_sent < phase_end) begin
                if ($urandom_range(99, 0) < 35) begin
                    case ($urandom_range(9, 0))
                        0:       configure(0, $urandom_range(5, 0));
                        1:       configure($urandom_range(40, 10), $urandom_range(3, 1));
                        2:       configure($urandom_range(6, 1), 0);
                        default: configure($urandom_range(8, 1), $urandom_range(6, 1));
                    endcase
                end
                send_frame(4);
            end
        end

        // a wider frame, run without idling
        configure(64, 2);
        send_frame(1);

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mf3s_pkg.sv
rtl/mf3s_front.sv
rtl/mf3s_queue.sv
rtl/mf3s_back.sv
rtl/median_filter_3x3_stream_top.sv
verif/median_filter_3x3_checker.sv
verif/testbench.sv
